// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and default sizes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizes
  localparam int unsigned SpqCapacity    = 64;
  localparam int unsigned SpqKeyBits     = 16;
  localparam int unsigned SpqPayloadBits = 16;

  // Operation codes carried on action_i
  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;       // capture key and payload operands
    logic    insert;     // place operand entry into the sorted row
    logic    remove;     // drop the head entry, shift the row down
    logic    show_head;  // report the head entry in the result word
    logic    report;     // update the result registers
    status_e status;     // status code of the result word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state controller: accept a command word, then execute it and emit
// one result word.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    action_i,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import spq_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] action_q;
  logic       done_q;

  // State and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  // Capture the operation code on accept
  always_ff @(posedge clk_i) begin
    if (cmd_o.load) begin
      action_q <= action_i;
    end
  end

  // Next state and command decode
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.status     = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.report = 1'b1;
        state_d      = S_IDLE;
        case (action_q)
          ACT_PUSH: begin
            if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.insert = 1'b1;
            end
          end
          ACT_POP: begin
            if (sts_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.remove    = 1'b1;
              cmd_o.show_head = 1'b1;
            end
          end
          ACT_PEEK: begin
            if (sts_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.show_head = 1'b1;
            end
          end
          default: begin
            cmd_o.status = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q == S_EXEC);
  assign done_o = done_q;

  // Checks
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE)
    else $error("execute state held longer than one cycle");
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_EXEC))
    else $error("result strobe without an executed word");
  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |-> !sts_i.full)
    else $error("insert issued into a full queue");
  a_no_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.remove |-> !sts_i.empty)
    else $error("remove issued on an empty queue");

endmodule

// File: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted row of key/payload cells with a parallel compare-and-shift insert,
// a shift-down remove, the entry count and the result registers.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned CAPACITY     = spq_pkg::SpqCapacity,
  parameter int unsigned KEY_BITS     = spq_pkg::SpqKeyBits,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::SpqPayloadBits,
  localparam int unsigned CntW        = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_pkg::cmd_t           cmd_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output spq_pkg::sts_t           sts_o,
  output logic [KEY_BITS-1:0]     head_key_o,
  output logic [PAYLOAD_BITS-1:0] head_payload_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         occupancy_o,
  output logic                    is_empty_o
);
  import spq_pkg::*;

  logic [KEY_BITS-1:0]     key_op_q;
  logic [PAYLOAD_BITS-1:0] pay_op_q;
  logic [KEY_BITS-1:0]     cell_key_q [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay_q [CAPACITY];
  logic [CntW-1:0]         count_q, count_d;
  logic [CAPACITY-1:0]     ins;

  logic [KEY_BITS-1:0]     head_key_q;
  logic [PAYLOAD_BITS-1:0] head_pay_q;
  status_e                 status_q;
  logic [CntW-1:0]         occ_q;
  logic                    empty_q;

  // Capture operands on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_op_q <= key_i;
      pay_op_q <= payload_i;
    end
  end

  // Flag cells at or past the insertion point (first strictly greater key,
  // or the first free cell)
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    assign ins[g] = (count_q == CntW'(g)) ||
                    ((CntW'(g) < count_q) && (cell_key_q[g] > key_op_q));
  end

  // Cell row: insert with shift up, or remove with shift down
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert && ins[g]) begin
          cell_key_q[g] <= key_op_q;
          cell_pay_q[g] <= pay_op_q;
        end else if (cmd_i.remove) begin
          cell_key_q[g] <= cell_key_q[g+1];
          cell_pay_q[g] <= cell_pay_q[g+1];
        end
      end
    end else if (g == CAPACITY - 1) begin : g_tail
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert && ins[g]) begin
          cell_key_q[g] <= ins[g-1] ? cell_key_q[g-1] : key_op_q;
          cell_pay_q[g] <= ins[g-1] ? cell_pay_q[g-1] : pay_op_q;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk_i) begin
        if (cmd_i.insert && ins[g]) begin
          cell_key_q[g] <= ins[g-1] ? cell_key_q[g-1] : key_op_q;
          cell_pay_q[g] <= ins[g-1] ? cell_pay_q[g-1] : pay_op_q;
        end else if (cmd_i.remove) begin
          cell_key_q[g] <= cell_key_q[g+1];
          cell_pay_q[g] <= cell_pay_q[g+1];
        end
      end
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      head_key_q <= cmd_i.show_head ? cell_key_q[0] : '0;
      head_pay_q <= cmd_i.show_head ? cell_pay_q[0] : '0;
      status_q   <= cmd_i.status;
      occ_q      <= count_d;
      empty_q    <= (count_d == '0);
    end
  end

  assign sts_o.full     = (count_q == CntW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign head_key_o     = head_key_q;
  assign head_payload_o = head_pay_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;
  assign is_empty_o     = empty_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.insert && !cmd_i.remove |=> $stable(count_q))
    else $error("entry count moved without insert or remove");
  a_free_cell_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sts_o.full |-> $countones(ins) >= 1)
    else $error("no insertion point found with free cells");

endmodule

// File: rtl/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue of key/payload entries, lowest key served first,
// equal keys served in arrival order.
//
// Channel   Direction  Handshake              Word
// command   in         start_i & !busy_o      action_i, key_i, payload_i
// result    out        done_o (one cycle)     head_key_o, head_payload_o,
//                                             status_o, occupancy_o,
//                                             is_empty_o
//
// Every command word is first captured, then executed in a compare-and-shift
// pass over the cell row, which all cells do in parallel.
// The result word appears with done_o in the cycle after execution, in which
// the next command word can already be accepted; none is taken while busy_o.
// Reset empties the queue at once; no clearing pass is needed.
// The receiver cannot stall: done_o marks each result word for one cycle only.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY     = spq_pkg::SpqCapacity,
  parameter int unsigned KEY_BITS     = spq_pkg::SpqKeyBits,
  parameter int unsigned PAYLOAD_BITS = spq_pkg::SpqPayloadBits,
  localparam int unsigned CntW        = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              action_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    done_o,
  output logic [KEY_BITS-1:0]     head_key_o,
  output logic [PAYLOAD_BITS-1:0] head_payload_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         occupancy_o,
  output logic                    is_empty_o
);
  import spq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each command word
  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Hold the sorted entries and the result word
  spq_datapath #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .sts_o          (sts),
    .head_key_o     (head_key_o),
    .head_payload_o (head_payload_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue_unit. A driver sends command
// words from a queue, a sorted-row predictor computes each result word on
// acceptance, and a monitor compares every done_o word field by field.
// Directed words cover empty, tie and extreme cases; random segments
// fill, drain and mix the queue under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int unsigned Cap        = SpqCapacity;
  localparam int unsigned KeyW       = SpqKeyBits;
  localparam int unsigned PayW       = SpqPayloadBits;
  localparam int unsigned CntW       = $clog2(Cap + 1);
  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned ResetLen   = 10;
  localparam int unsigned WordTarget = 900;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 8;
  // Unused action code: the block ignores it but still reports
  localparam logic [1:0]  ActNone    = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
    logic [6:0]      idle_pct;
    logic            wait_drain;
  } cmd_word_t;

  typedef struct packed {
    logic [KeyW-1:0] head_key;
    logic [PayW-1:0] head_payload;
    logic [1:0]      status;
    logic [CntW-1:0] occupancy;
    logic            is_empty;
  } result_word_t;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            start_i   = 1'b0;
  logic [1:0]      action_i  = ACT_PUSH;
  logic [KeyW-1:0] key_i     = '0;
  logic [PayW-1:0] payload_i = '0;
  logic            busy_o;
  logic            done_o;
  logic [KeyW-1:0] head_key_o;
  logic [PayW-1:0] head_payload_o;
  logic [1:0]      status_o;
  logic [CntW-1:0] occupancy_o;
  logic            is_empty_o;

  cmd_word_t    pending_cmds[$];
  result_word_t expected_results[$];
  result_word_t oldest_result;
  int unsigned  words_made   = 0;
  int unsigned  idle_cycles  = 0;
  int unsigned  mismatch_cnt = 0;

  // Predicted queue contents: slot 0 is the head
  logic [KeyW-1:0] row_key[Cap];
  logic [PayW-1:0] row_payload[Cap];
  int unsigned     row_count = 0;

  stable_priority_queue_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .done_o         (done_o),
    .head_key_o     (head_key_o),
    .head_payload_o (head_payload_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Apply one command word to the predicted row and return its result word
  function automatic result_word_t apply_queue_op(cmd_word_t w);
    result_word_t r;
    int unsigned  pos;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_PUSH: begin
        if (row_count >= Cap) begin
          r.status = ST_FULL;
        end else begin
          // insert after every entry with an equal key
          pos = 0;
          while (pos < row_count && row_key[pos] <= w.key) pos++;
          for (int i = row_count; i > pos; i--) begin
            row_key[i]     = row_key[i-1];
            row_payload[i] = row_payload[i-1];
          end
          row_key[pos]     = w.key;
          row_payload[pos] = w.payload;
          row_count++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (row_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_key     = row_key[0];
          r.head_payload = row_payload[0];
          if (w.action == ACT_POP) begin
            for (int i = 1; i < row_count; i++) begin
              row_key[i-1]     = row_key[i];
              row_payload[i-1] = row_payload[i];
            end
            row_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = CntW'(row_count);
    r.is_empty  = (row_count == 0);
    return r;
  endfunction

  // Append a command word; idle rate follows the word's position in the run
  task automatic queue_word(logic [1:0] act, logic [KeyW-1:0] k, logic [PayW-1:0] p);
    cmd_word_t   w;
    int unsigned phase;
    phase = (words_made / 120) % 4;
    w.action     = act;
    w.key        = k;
    w.payload    = p;
    w.idle_pct   = (phase == 1) ? 7'd70 : (phase == 2) ? 7'd22 : 7'd0;
    w.wait_drain = (words_made % 200 == 150);
    pending_cmds.push_back(w);
    words_made++;
  endtask

  // Draw a key: half the time a narrow range for ties, else extremes or full range
  function automatic logic [KeyW-1:0] draw_key();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return KeyW'($urandom_range(7));
    if (sel == 5) return ($urandom_range(1) != 0) ? '1 : '0;
    return KeyW'($urandom);
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Driver: hold a word while busy, otherwise present the next one or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      action_i  <= ACT_PUSH;
      key_i     <= '0;
      payload_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        expected_results.push_back(apply_queue_op(pending_cmds.pop_front()));
      end
      if (start_i && busy_o) begin
        // hold the current word
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].wait_drain && expected_results.size() != 0) &&
                   $urandom_range(99) >= pending_cmds[0].idle_pct) begin
        start_i   <= 1'b1;
        action_i  <= pending_cmds[0].action;
        key_i     <= pending_cmds[0].key;
        payload_i <= pending_cmds[0].payload;
      end else begin
        // idle with noise on the word lines
        start_i   <= 1'b0;
        action_i  <= 2'($urandom);
        key_i     <= KeyW'($urandom);
        payload_i <= PayW'($urandom);
      end
    end
  end

  // Monitor: check each result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_cnt++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("head_key", oldest_result.head_key, head_key_o);
          check_field("head_payload", oldest_result.head_payload, head_payload_o);
          check_field("status", oldest_result.status, status_o);
          check_field("occupancy", oldest_result.occupancy, occupancy_o);
          check_field("is_empty", oldest_result.is_empty, is_empty_o);
        end
      end
      // watchdog: count cycles in which no word moves
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    int unsigned roll;

    // empty queue: peek, pop and the unused code
    queue_word(ACT_PEEK, '0, '0);
    queue_word(ACT_POP, '1, '1);
    queue_word(ActNone, '1, '1);
    // extremes, then a run of equal keys
    queue_word(ACT_PUSH, '1, '0);
    queue_word(ACT_PUSH, '0, '1);
    queue_word(ACT_PUSH, KeyW'(5), PayW'(1));
    queue_word(ACT_PUSH, KeyW'(5), PayW'(2));
    queue_word(ACT_PUSH, KeyW'(5), PayW'(3));
    queue_word(ActNone, KeyW'($urandom), PayW'($urandom));
    queue_word(ACT_PEEK, '0, '0);
    queue_word(ACT_POP, '0, '0);
    queue_word(ACT_POP, '0, '0);
    queue_word(ACT_PEEK, '0, '0);
    queue_word(ACT_POP, '0, '0);
    queue_word(ACT_PUSH, KeyW'(5), PayW'(4));
    queue_word(ACT_PUSH, KeyW'(16'hAAAA), PayW'(16'h5555));
    queue_word(ACT_PUSH, KeyW'(16'h5555), PayW'(16'hAAAA));
    // drain past empty
    repeat (7) queue_word(ACT_POP, '0, '0);

    // random segments: fill past full, drain past empty, or mix
    while (words_made < WordTarget) begin
      mode    = $urandom_range(3);
      seg_len = $urandom_range(40, 140);
      repeat (seg_len) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          queue_word(ActNone, KeyW'($urandom), PayW'($urandom));
        end else if ((mode <= 1 && roll < 85) || (mode == 3 && roll < 50)) begin
          queue_word(ACT_PUSH, draw_key(), PayW'($urandom));
        end else if (roll % 4 == 0) begin
          queue_word(ACT_PEEK, KeyW'($urandom), PayW'($urandom));
        end else if (mode == 2 || mode == 3 || roll >= 85) begin
          queue_word(ACT_POP, KeyW'($urandom), PayW'($urandom));
        end else begin
          queue_word(ACT_PUSH, draw_key(), PayW'($urandom));
        end
      end
    end

    // release reset away from the active edge
    repeat (ResetLen) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue_unit.sv
dv/tb.sv
